>>> rtl/kte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kte_pkg
// Shared types, constants and the key table for the multi-tap text entry.
// ----------------------------------------------------------------------------
package kte_pkg;

  localparam int TIME_BITS = 32;
  localparam int KEY_W     = 5;
  localparam int CHAR_W    = 8;
  localparam int TAP_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  localparam logic [KEY_W-1:0] KEY_NONE = '0;
  localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(16);

  localparam logic [CFG_W-1:0] COMMIT_INTERVAL_RST = CFG_W'(250000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA_MODE      = 1'b0,
    REG_COMMIT_INTERVAL = 1'b1
  } kte_reg_t;

  typedef enum logic [1:0] {
    KIND_TAP   = 2'd0,
    KIND_FIXED = 2'd1,
    KIND_NOW   = 2'd2
  } kte_kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   raw;
    kte_kind_t           kind;
    logic [TAP_W-1:0]    count;
    logic [5*CHAR_W-1:0] list;
  } kte_key_t;

  typedef struct packed {
    logic [KEY_W-1:0]     prev_key;
    logic [TAP_W-1:0]     tap_count;
    logic [CHAR_W-1:0]    pending_char;
    logic [TIME_BITS-1:0] press_time;
    logic                 locked_out;
  } kte_state_t;

  localparam kte_state_t STATE_RST = '{
    prev_key:     KEY_NONE,
    tap_count:    '0,
    pending_char: '0,
    press_time:   '0,
    locked_out:   1'b1
  };

  // list holds entries packed low byte first
  function automatic kte_key_t key_info(input logic [KEY_W-1:0] k);
    kte_key_t d;
    d = '{raw: 8'h00, kind: KIND_NOW, count: 3'd0, list: '0};
    case (k)
      5'd1:  d = '{raw: "1", kind: KIND_TAP,   count: 3'd4, list: {8'h00, "1", "?", ",", "."}};
      5'd2:  d = '{raw: "2", kind: KIND_TAP,   count: 3'd4, list: {8'h00, "2", "c", "b", "a"}};
      5'd3:  d = '{raw: "3", kind: KIND_TAP,   count: 3'd4, list: {8'h00, "3", "f", "e", "d"}};
      5'd4:  d = '{raw: "<", kind: KIND_NOW,   count: 3'd0, list: '0};
      5'd5:  d = '{raw: "4", kind: KIND_TAP,   count: 3'd4, list: {8'h00, "4", "i", "h", "g"}};
      5'd6:  d = '{raw: "5", kind: KIND_TAP,   count: 3'd4, list: {8'h00, "5", "l", "k", "j"}};
      5'd7:  d = '{raw: "6", kind: KIND_TAP,   count: 3'd4, list: {8'h00, "6", "o", "n", "m"}};
      5'd8:  d = '{raw: "-", kind: KIND_NOW,   count: 3'd0, list: '0};
      5'd9:  d = '{raw: "7", kind: KIND_TAP,   count: 3'd5, list: {"7", "s", "r", "q", "p"}};
      5'd10: d = '{raw: "8", kind: KIND_TAP,   count: 3'd4, list: {8'h00, "8", "v", "u", "t"}};
      5'd11: d = '{raw: "9", kind: KIND_TAP,   count: 3'd5, list: {"9", "z", "y", "x", "w"}};
      5'd12: d = '{raw: "+", kind: KIND_NOW,   count: 3'd0, list: '0};
      5'd13: d = '{raw: "*", kind: KIND_FIXED, count: 3'd1, list: {32'h0, "*"}};
      5'd14: d = '{raw: "0", kind: KIND_TAP,   count: 3'd2, list: {24'h0, "0", " "}};
      5'd15: d = '{raw: "#", kind: KIND_FIXED, count: 3'd1, list: {32'h0, "#"}};
      5'd16: d = '{raw: ">", kind: KIND_NOW,   count: 3'd0, list: '0};
      default: d = '{raw: 8'h00, kind: KIND_NOW, count: 3'd0, list: '0};
    endcase
    return d;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_letter(input logic [5*CHAR_W-1:0] list,
                                                    input logic [TAP_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      3'd0:    c = list[0*CHAR_W +: CHAR_W];
      3'd1:    c = list[1*CHAR_W +: CHAR_W];
      3'd2:    c = list[2*CHAR_W +: CHAR_W];
      3'd3:    c = list[3*CHAR_W +: CHAR_W];
      3'd4:    c = list[4*CHAR_W +: CHAR_W];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/kte_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kte_step
// Per-poll decode: key lookup, tap cycling and commit timeout check.
// ----------------------------------------------------------------------------
module kte_step (
  input  logic [kte_pkg::KEY_W-1:0]     key_index,
  input  logic [kte_pkg::CFG_W-1:0]     now_us,
  input  logic                          alpha_mode,
  input  logic [kte_pkg::CFG_W-1:0]     commit_interval,
  input  kte_pkg::kte_state_t           state_cur,
  output kte_pkg::kte_state_t           state_nxt,
  output logic [kte_pkg::CHAR_W-1:0]    char_out
);
  import kte_pkg::*;

  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic [KEY_W-1:0]     key;
  kte_key_t             desc;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic [TAP_W-1:0]     tap;
  logic                 done;

  assign key   = (key_index > KEY_LAST) ? KEY_NONE : key_index;
  assign desc  = key_info(key);
  assign now_t = TIME_BITS'(now_us);

  always_comb begin
    state_nxt = state_cur;
    char_out  = '0;
    done      = 1'b0;
    tap       = '0;
    elapsed   = '0;
    if (!alpha_mode) begin
      char_out = desc.raw;
    end else begin
      if (key != KEY_NONE) begin
        tap = (key != state_cur.prev_key) ? '0 : state_cur.tap_count;
        state_nxt.prev_key   = key;
        state_nxt.press_time = now_t;
        state_nxt.locked_out = 1'b0;
        case (desc.kind)
          KIND_TAP: begin
            tap = (tap < desc.count) ? tap + 3'd1 : 3'd1;
            state_nxt.tap_count    = tap;
            state_nxt.pending_char = pick_letter(desc.list, tap - 3'd1);
          end
          KIND_FIXED: begin
            state_nxt.tap_count    = tap;
            state_nxt.pending_char = pick_letter(desc.list, 3'd0);
          end
          default: begin
            state_nxt.pending_char = desc.raw;
            state_nxt.prev_key     = KEY_NONE;
            state_nxt.tap_count    = '0;
            state_nxt.locked_out   = 1'b1;
            char_out               = desc.raw;
            done                   = 1'b1;
          end
        endcase
      end
      elapsed = now_t - state_nxt.press_time;
      if (!done && !state_nxt.locked_out &&
          (CMP_W'(elapsed) >= CMP_W'(commit_interval))) begin
        state_nxt.prev_key   = KEY_NONE;
        state_nxt.tap_count  = '0;
        state_nxt.locked_out = 1'b1;
        char_out             = state_nxt.pending_char;
      end
    end
  end

endmodule

>>> rtl/multitap_keypad_text_entry_top.sv
`timescale 1ns / 1ps
// Path: an accepted poll is held in the input register, then its result in the result register.
// Throughput: one poll per cycle; the key step is a single registered pass.
// Both registers stall only when the result register is full and not taken.
// Reset (rst_n low, synchronous): empties both stages, clears the entry state,
// sets pass-through mode and a commit interval of 250000 us.
// ----------------------------------------------------------------------------
// multitap_keypad_text_entry_top
// Multi-tap text entry from 4x4 keypad polls, valid/ready on all channels.
// ----------------------------------------------------------------------------
module multitap_keypad_text_entry_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [kte_pkg::KEY_W-1:0]        in_key_index,
  input  logic [kte_pkg::CFG_W-1:0]        in_now_us,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [kte_pkg::CHAR_W-1:0]       out_char_out,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kte_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kte_pkg::CFG_W-1:0]        cfg_data
);
  import kte_pkg::*;

  logic                 alpha_r;
  logic [CFG_W-1:0]     interval_r;
  logic                 in_valid_r;
  logic [KEY_W-1:0]     key_r;
  logic [CFG_W-1:0]     now_r;
  kte_state_t           state_r;
  kte_state_t           state_nxt;
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    char_r;
  logic [CHAR_W-1:0]    char_nxt;
  logic                 advance;
  logic                 process;

  assign advance   = out_ready || !out_valid_r;
  assign process   = in_valid_r && advance;
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_valid    = out_valid_r;
  assign out_char_out = char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r    <= 1'b0;
      interval_r <= COMMIT_INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (kte_reg_t'(cfg_index))
        REG_ALPHA_MODE:      alpha_r    <= cfg_data[0];
        REG_COMMIT_INTERVAL: interval_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_r <= in_key_index;
      now_r <= in_now_us;
    end
  end

  kte_step u_step (
    .key_index       (key_r),
    .now_us          (now_r),
    .alpha_mode      (alpha_r),
    .commit_interval (interval_r),
    .state_cur       (state_r),
    .state_nxt       (state_nxt),
    .char_out        (char_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else if (process) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      char_r <= char_nxt;
    end
  end

  a_locked_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.locked_out |-> (state_r.prev_key == KEY_NONE && state_r.tap_count == '0))
    else $error("locked state carries a key or tap count");

  a_prev_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.prev_key <= KEY_LAST)
    else $error("previous key out of range");

  a_pass_through_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (process && !alpha_r) |=> $stable(state_r))
    else $error("pass-through poll changed entry state");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> in_valid_r)
    else $error("accepted transaction not held in input stage");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    process |=> out_valid_r)
    else $error("processed poll produced no result");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the multi-tap keypad text entry block against a cycle-free predictor
// of its poll behavior. Key polls are driven at the falling edge from a queue
// with random idle gaps and result back-pressure; register writes by a task.
// Every result is compared in order with the predicted character.
// ----------------------------------------------------------------------------
module testbench;
  import kte_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [TIME_BITS-1:0] now_us;
  } poll_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [KEY_W-1:0]     in_key_index = '0;
  logic [CFG_W-1:0]     in_now_us    = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [CHAR_W-1:0]    out_char_out;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;

  multitap_keypad_text_entry_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_key_index (in_key_index),
    .in_now_us    (in_now_us),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_out (out_char_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // predictor copy of configuration and entry state
  logic                 mdl_alpha    = 1'b0;
  logic [CFG_W-1:0]     mdl_interval = COMMIT_INTERVAL_RST;
  logic [KEY_W-1:0]     mdl_prev_key = KEY_NONE;
  logic [TAP_W-1:0]     mdl_taps     = '0;
  logic [CHAR_W-1:0]    mdl_pending  = '0;
  logic [TIME_BITS-1:0] mdl_press    = '0;
  logic                 mdl_locked   = 1'b1;

  poll_t                poll_q[$];
  logic [CHAR_W-1:0]    expected_chars[$];
  logic [CHAR_W-1:0]    want;
  poll_t                next_poll;
  int                   polls_sent   = 0;
  int                   polls_taken  = 0;
  int                   errors       = 0;
  int                   idle_cycles  = 0;
  int                   in_gap       = 0;
  int                   out_stall    = 0;
  bit                   quiet        = 1'b0;
  logic                 in_acc       = 1'b0;
  logic                 out_acc      = 1'b0;
  logic                 cfg_acc      = 1'b0;
  logic [CFG_W-1:0]     cur_iv       = COMMIT_INTERVAL_RST;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CHAR_W-1:0] key_symbol(input logic [KEY_W-1:0] k);
    string symbols;
    symbols = "?123<456-789+*0#>";
    if (k == KEY_NONE || k > KEY_LAST) return '0;
    return symbols[k];
  endfunction

  function automatic string key_letters(input logic [KEY_W-1:0] k);
    case (k)
      5'd1:    return ".,?1";
      5'd2:    return "abc2";
      5'd3:    return "def3";
      5'd5:    return "ghi4";
      5'd6:    return "jkl5";
      5'd7:    return "mno6";
      5'd9:    return "pqrs7";
      5'd10:   return "tuv8";
      5'd11:   return "wxyz9";
      5'd13:   return "*";
      5'd14:   return " 0";
      5'd15:   return "#";
      default: return "";
    endcase
  endfunction

  function automatic kte_kind_t key_kind(input logic [KEY_W-1:0] k);
    if (k == 5'd13 || k == 5'd15) return KIND_FIXED;
    if (key_letters(k).len() != 0) return KIND_TAP;
    return KIND_NOW;
  endfunction

  function automatic logic [CHAR_W-1:0] decode_poll(input logic [KEY_W-1:0]     key_in,
                                                    input logic [TIME_BITS-1:0] now);
    logic [KEY_W-1:0]     k;
    string                letters;
    logic [TIME_BITS-1:0] elapsed;
    k = (key_in > KEY_LAST) ? KEY_NONE : key_in;
    if (!mdl_alpha) return key_symbol(k);
    if (k != KEY_NONE) begin
      letters = key_letters(k);
      if (k != mdl_prev_key) mdl_taps = '0;
      mdl_prev_key = k;
      mdl_press    = now;
      mdl_locked   = 1'b0;
      case (key_kind(k))
        KIND_TAP: begin
          mdl_taps    = (int'(mdl_taps) < letters.len()) ? mdl_taps + 3'd1 : 3'd1;
          mdl_pending = letters[int'(mdl_taps) - 1];
        end
        KIND_FIXED: begin
          mdl_pending = letters[0];
        end
        default: begin
          mdl_pending  = key_symbol(k);
          mdl_prev_key = KEY_NONE;
          mdl_taps     = '0;
          mdl_locked   = 1'b1;
          return key_symbol(k);
        end
      endcase
    end
    elapsed = now - mdl_press;
    if (!mdl_locked && elapsed >= mdl_interval) begin
      mdl_prev_key = KEY_NONE;
      mdl_taps     = '0;
      mdl_locked   = 1'b1;
      return mdl_pending;
    end
    return '0;
  endfunction

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  // sample handshakes, predict, check and watch for a hang
  always @(posedge clk) begin
    in_acc  <= in_valid && in_ready;
    out_acc <= out_valid && out_ready;
    cfg_acc <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ALPHA_MODE:      mdl_alpha = cfg_data[0];
          REG_COMMIT_INTERVAL: mdl_interval = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_chars.push_back(decode_poll(in_key_index, in_now_us));
        polls_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) $display("unexpected transaction: char_out %h", out_char_out);
        end else begin
          want = expected_chars.pop_front();
          if (out_char_out !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("char_out mismatch: expected %h actual %h", want, out_char_out);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // poll driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_acc) begin
        // hold until accepted
      end else if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (poll_q.size() != 0) begin
        next_poll = poll_q.pop_front();
        polls_sent++;
        in_valid     <= 1'b1;
        in_key_index <= next_poll.key;
        in_now_us    <= next_poll.now_us;
        in_gap = draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_acc) out_stall = draw_wait();
      if (out_stall != 0) begin
        out_ready <= 1'b0;
        out_stall = out_stall - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_poll(input int key, input logic [TIME_BITS-1:0] now);
    poll_t p;
    p.key    = KEY_W'(key);
    p.now_us = now;
    poll_q.push_back(p);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (poll_q.size() != 0 || polls_sent != polls_taken || expected_chars.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input kte_reg_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk);
    while (!cfg_acc);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(input bit alpha, input logic [CFG_W-1:0] iv);
    wait_idle();
    write_reg(REG_ALPHA_MODE, CFG_W'(alpha));
    write_reg(REG_COMMIT_INTERVAL, iv);
    cur_iv = iv;
  endtask

  function automatic logic [TIME_BITS-1:0] short_step();
    if (cur_iv == 0) return $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) return $urandom % cur_iv;
    return $urandom_range(0, 63);
  endfunction

  task automatic run_random(input int n);
    int                   sent;
    int                   presses;
    int                   key;
    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS-1:0] last_t;
    sent   = 0;
    t      = $urandom();
    last_t = t;
    while (sent < n) begin
      if ($urandom_range(0, 15) == 0) quiet = ~quiet;
      if ($urandom_range(0, 9) < 7) begin
        key     = $urandom_range(1, 16);
        presses = $urandom_range(1, 6);
        repeat (presses) begin
          push_poll(key, t);
          last_t = t;
          sent++;
          t = t + short_step();
          if ($urandom_range(0, 4) == 0) begin
            push_poll(0, t);
            sent++;
          end
        end
        // land on either side of the commit boundary
        t = last_t + cur_iv - 1 + $urandom_range(0, 2);
        push_poll(0, t);
        sent++;
        if ($urandom_range(0, 1) == 0) begin
          t = last_t + cur_iv;
          push_poll($urandom_range(0, 3) == 0 ? $urandom_range(17, 31) : 0, t);
          sent++;
        end
      end else begin
        t = ($urandom_range(0, 1) == 0) ? $urandom() : t + $urandom_range(0, 3);
        push_poll($urandom_range(0, 31), t);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pass-through at reset settings
    push_poll(0, 32'h0000_0000);
    push_poll(4, 32'hFFFF_FFFF);
    push_poll(13, 32'h0000_0000);
    push_poll(17, 32'hFFFF_FFFF);
    push_poll(31, 32'h1234_5678);

    set_mode(1'b1, 32'd100);
    push_poll(2, 0);
    push_poll(2, 10);
    push_poll(2, 20);
    push_poll(2, 30);
    push_poll(2, 40);
    push_poll(0, 140);
    push_poll(11, 200);
    push_poll(11, 210);
    push_poll(3, 220);
    push_poll(8, 230);
    push_poll(13, 500);
    push_poll(13, 510);
    push_poll(0, 610);
    push_poll(15, 700);
    push_poll(14, 710);
    push_poll(14, 720);
    push_poll(20, 820);
    push_poll(9, 32'hFFFF_FFF0);
    push_poll(0, 32'h0000_0053);
    push_poll(0, 32'h0000_0054);
    push_poll(4, 900);
    push_poll(12, 910);
    push_poll(16, 920);

    set_mode(1'b1, 32'd0);
    push_poll(5, 123);

    set_mode(1'b1, 32'hFFFF_FFFF);
    push_poll(2, 0);
    push_poll(0, 32'hFFFF_FFFF);

    set_mode(1'b1, $urandom_range(1, 64));
    run_random(70);
    set_mode(1'b0, $urandom());
    run_random(70);
    set_mode(1'b1, 32'd0);
    run_random(70);
    set_mode(1'b1, 32'hFFFF_FFFF);
    run_random(70);
    set_mode(1'b1, COMMIT_INTERVAL_RST);
    run_random(70);
    set_mode(1'b1, $urandom_range(1, 2000));
    run_random(70);

    wait_idle();
    repeat (10) @(negedge clk);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
